@@ rtl/aesc_pkg.sv @@
package aesc_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RegAddrW  = 5;

  localparam logic [RegAddrW-1:0] RegKeyHigh = 5'h00;
  localparam logic [RegAddrW-1:0] RegKeyLow  = 5'h08;
  localparam logic [RegAddrW-1:0] RegIvHigh  = 5'h10;
  localparam logic [RegAddrW-1:0] RegIvLow   = 5'h18;

  typedef logic [7:0] byte_t;

  // Forward S-box as a constant lookup.
  function automatic byte_t sbox(input byte_t x);
    byte_t tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tab[x];
  endfunction

  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round constant (doubling in GF(2^8)).
  function automatic byte_t rcon_next(input byte_t r);
    return xtime(r);
  endfunction

endpackage

@@ rtl/aesc_round.sv @@
module aesc_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         last_i,
  input  logic [127:0] key_i,
  input  logic [7:0]   rcon_i,
  output logic [127:0] state_o,
  output logic [127:0] key_o
);
  import aesc_pkg::*;

  byte_t s  [16];
  byte_t sb [16];
  byte_t sr [16];
  byte_t mc [16];
  logic [31:0] w [4];
  logic [31:0] nw [4];
  logic [31:0] t;

  // Round datapath: SubBytes, ShiftRows, MixColumns (skipped on last), AddRoundKey.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i]  = state_i[127-8*i -: 8];
      sb[i] = sbox(s[i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[4*c+r] = sb[4*((c+r)%4)+r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mc[4*c]   = xtime(sr[4*c]) ^ xtime(sr[4*c+1]) ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c+1] = sr[4*c] ^ xtime(sr[4*c+1]) ^ xtime(sr[4*c+2]) ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ xtime(sr[4*c+2]) ^ xtime(sr[4*c+3]) ^ sr[4*c+3];
      mc[4*c+3] = xtime(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ xtime(sr[4*c+3]);
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127-8*i -: 8] = (last_i ? sr[i] : mc[i]) ^ rkey_i[127-8*i -: 8];
    end
  end

  // One step of the key schedule: four new words from the previous round key.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = key_i[127-32*i -: 32];
    end
    t = {sbox(w[3][23:16]) ^ rcon_i, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
    nw[0] = w[0] ^ t;
    nw[1] = w[1] ^ nw[0];
    nw[2] = w[2] ^ nw[1];
    nw[3] = w[3] ^ nw[2];
    key_o = {nw[0], nw[1], nw[2], nw[3]};
  end

endmodule

@@ rtl/aes128_ctr_cipher.sv @@
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      data_high, data_low, valid_bytes, first_block
// m_axis    out        m_axis_tvalid/tready      out_high, out_low, out_valid_bytes
// apb       in         psel/penable/pwrite       key_high, key_low, iv_high, iv_low
//
// An item is loaded, runs its rounds in the round state and then waits in the output state.
// The single round unit is shared by all ten rounds; round keys are stored
// in a small memory filled during the first block of a message.
// The block takes no new item until the result has been accepted downstream.
// Reset clears the control state, configuration registers and the counter.
module aes128_ctr_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [63:0] data_high, [127:64] data_low, [132:128] valid_bytes, [135:133] zero
  input  logic [135:0]  s_axis_tdata,
  // [0] first_block
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [63:0] out_high, [127:64] out_low, [132:128] out_valid_bytes, [135:133] zero
  output logic [135:0]  m_axis_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [aesc_pkg::RegAddrW-1:0] paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import aesc_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StOut   = 2'd2;

  logic [1:0]   st_q, st_d;
  logic [3:0]   rnd_q;
  logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic [127:0] ctr_q;
  logic [127:0] state_q;
  logic [127:0] rkey_q;
  logic [127:0] data_q;
  logic [4:0]   nbytes_q;
  logic         expand_q;
  logic [7:0]   rcon_q;
  logic [127:0] rk_mem [NumRounds+1];
  logic [127:0] round_out, key_out;
  logic [127:0] mask;
  logic [127:0] out_blk;
  logic         acc_in, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign acc_in = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = (st_q == StOut);

  always_comb begin
    case (paddr)
      RegKeyHigh: prdata = key_high_q;
      RegKeyLow:  prdata = key_low_q;
      RegIvHigh:  prdata = iv_high_q;
      RegIvLow:   prdata = iv_low_q;
      default:    prdata = '0;
    endcase
  end

  aesc_round u_round (
    .state_i (state_q),
    .rkey_i  (expand_q ? key_out : rkey_q),
    .last_i  (rnd_q == 4'(NumRounds)),
    .key_i   (rkey_q),
    .rcon_i  (rcon_q),
    .state_o (round_out),
    .key_o   (key_out)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (acc_in) st_d = StRound;
      StRound: if (rnd_q == 4'(NumRounds)) st_d = StOut;
      StOut:   if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      ctr_q      <= '0;
      rnd_q      <= '0;
      expand_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_wr) begin
        case (paddr)
          RegKeyHigh: key_high_q <= pwdata;
          RegKeyLow:  key_low_q  <= pwdata;
          RegIvHigh:  iv_high_q  <= pwdata;
          RegIvLow:   iv_low_q   <= pwdata;
          default:    ;
        endcase
      end
      if (acc_in) begin
        rnd_q    <= 4'd1;
        expand_q <= s_axis_tuser;
        // The counter used by this item is folded into state at load; advance now.
        if (s_axis_tuser) ctr_q <= {iv_high_q, iv_low_q} + 128'd1;
        else ctr_q <= ctr_q + 128'd1;
      end else if (st_q == StRound) begin
        rnd_q <= rnd_q + 4'd1;
      end
    end
  end

  // Datapath registers and round-key memory: no reset needed.
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      data_q   <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
      nbytes_q <= s_axis_tdata[132:128];
      rcon_q   <= 8'h01;
      if (s_axis_tuser) begin
        rkey_q     <= {key_high_q, key_low_q};
        rk_mem[0]  <= {key_high_q, key_low_q};
        state_q    <= {iv_high_q, iv_low_q} ^ {key_high_q, key_low_q};
      end else begin
        rkey_q  <= rk_mem[1];
        state_q <= ctr_q ^ rk_mem[0];
      end
    end else if (st_q == StRound) begin
      state_q <= round_out;
      rcon_q  <= rcon_next(rcon_q);
      if (expand_q) begin
        rk_mem[rnd_q] <= key_out;
        rkey_q        <= key_out;
      end else if (rnd_q != 4'(NumRounds)) begin
        rkey_q <= rk_mem[rnd_q + 4'd1];
      end
    end
  end

  // Zero bytes at and past the valid count (counts above 16 keep all bytes).
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127-8*i -: 8] = (5'(i) < nbytes_q || nbytes_q[4]) ? 8'hff : 8'h00;
    end
  end

  // Byte 0 sits in the top bits of out_blk; out_high goes to the low lanes.
  assign out_blk      = (state_q ^ data_q) & mask;
  assign m_axis_tdata = {3'b000, nbytes_q, out_blk[63:0], out_blk[127:64]};

  // Results appear only after all ten rounds have run.
  a_out_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rnd_q) == 4'(NumRounds))
    else $error("result shown before last round");
  // No input is taken while a block is in flight.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready)
    else $error("accepted while busy");
  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

@@ dv/aes128_ctr_cipher_tb.sv @@
`timescale 1ns / 1ps

// Self-checking testbench for the AES-128 counter-mode cipher.
// Items go in on the slave stream, results come out on the master stream, and
// every result is compared with a software model of AES-128 CTR kept in this
// module. Keys and IVs are written over APB only while the block is idle.
module aes128_ctr_cipher_tb;
  import aesc_pkg::*;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [135:0]  s_axis_tdata;
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [135:0]  m_axis_tdata;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [63:0]   pwdata;
  logic [63:0]   prdata;
  logic          pready;

  aes128_ctr_cipher dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
  } cipher_res_t;

  // S-box kept locally so that the model does not share code with the design.
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Model state: the register shadows, the expanded key and the counter.
  logic [63:0]  cfg_regs [4];
  logic [31:0]  sched_words [44];
  logic [127:0] ctr_q;

  cipher_res_t  pending_results [$];
  int unsigned  n_errors;
  int unsigned  idle_pct_in, idle_pct_out;
  bit           hold_off_req;

  function automatic logic [7:0] gmul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched_words[0] = cfg_regs[0][63:32];
    sched_words[1] = cfg_regs[0][31:0];
    sched_words[2] = cfg_regs[1][63:32];
    sched_words[3] = cfg_regs[1][31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX[t[31:24]] ^ rc, SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
        rc = gmul2(rc);
      end
      sched_words[i] = sched_words[i-4] ^ t;
    end
  endfunction

  // Encrypts the current counter; state byte k is bits 127-8k down.
  function automatic logic [127:0] keystream_block();
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    for (int k = 0; k < 16; k++) s[k] = ctr_q[127-8*k -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        for (int k = 0; k < 16; k++) s[k] = SBOX[s[k]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c+r)%4)+r];
        s = t;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            s[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
            s[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
            s[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
            s[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[4*c+r] ^= sched_words[rnd*4+c][31-8*r -: 8];
    end
    for (int k = 0; k < 16; k++) keystream_block[127-8*k -: 8] = s[k];
  endfunction

  // Advances the model by one item and returns the ciphertext it predicts.
  function automatic cipher_res_t ctr_encrypt(input logic [127:0] blk,
                                              input logic [4:0] nb, input logic first);
    cipher_res_t res;
    logic [127:0] ks, x;
    int lim;
    if (first) begin
      expand_schedule();
      ctr_q = {cfg_regs[2], cfg_regs[3]};
    end
    ks  = keystream_block();
    x   = blk ^ ks;
    lim = (nb > 16) ? 16 : nb;
    for (int k = lim; k < 16; k++) x[127-8*k -: 8] = 8'h00;
    ctr_q = ctr_q + 128'd1;
    res.hi = x[127:64];
    res.lo = x[63:0];
    res.nbytes = nb;
    return res;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: stalls at random, plus one long hold-off on request so that
  // the block backs up and drops s_axis_tready while items keep coming.
  initial begin
    int hold_cnt;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 300; hold_cnt++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct_out);
    end
  end

  // Checker: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    cipher_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting: %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.hi) begin
          $error("out_high expected %h actual %h", want.hi, m_axis_tdata[63:0]);
          n_errors++;
        end
        if (m_axis_tdata[127:64] !== want.lo) begin
          $error("out_low expected %h actual %h", want.lo, m_axis_tdata[127:64]);
          n_errors++;
        end
        if (m_axis_tdata[132:128] !== want.nbytes) begin
          $error("out_valid_bytes expected %0d actual %0d", want.nbytes,
                 m_axis_tdata[132:128]);
          n_errors++;
        end
      end
    end
  end

  // APB write with a setup phase and an access phase; the register takes the value at the access edge.
  task automatic apb_write(input int idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RegAddrW'(idx * 8); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_regs[idx] = val;
  endtask

  task automatic load_key_iv(input logic [63:0] kh, kl, ivh, ivl);
    apb_write(0, kh);
    apb_write(1, kl);
    apb_write(2, ivh);
    apb_write(3, ivl);
  endtask

  // Offers one item, holding valid until the block takes it, and records the
  // prediction at the accepting edge. Valid stays high into the next item.
  task automatic send_block(input logic [127:0] blk, input logic [4:0] nb,
                            input logic first, input logic [127:0] exp_blk,
                            input bit exp_given);
    cipher_res_t res;
    while ($urandom_range(99) < idle_pct_in) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, nb, blk[63:0], blk[127:64]};
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    res = ctr_encrypt(blk, nb, first);
    if (exp_given && {res.hi, res.lo} !== exp_blk) begin
      $error("out_block expected %h actual %h", exp_blk, {res.hi, res.lo});
      n_errors++;
    end
    pending_results.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  typedef struct {
    logic [127:0] blk;
    logic [4:0]   nb;
    logic         first;
    logic [127:0] exp_blk;
    bit           exp_given;
  } vec_row_t;

  // Directed rows under the FIPS-197 key 000102..0f with IV 00112233..ff: the
  // first block is the standard known-answer vector, so its result is typed
  // in. Then extremes of the data, partial blocks, a zero count, counts above
  // sixteen, and a counter that wraps past all ones.
  vec_row_t dir_rows [] = '{
    '{128'h0, 5'd16, 1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1},
    '{{128{1'b1}}, 5'd16, 1'b0, 128'h0, 1'b0},
    '{128'h0, 5'd16, 1'b0, 128'h0, 1'b0},
    '{128'h0123456789abcdeffedcba9876543210, 5'd1, 1'b0, 128'h0, 1'b0},
    '{{128{1'b1}}, 5'd7, 1'b0, 128'h0, 1'b0},
    '{{128{1'b1}}, 5'd8, 1'b0, 128'h0, 1'b0},
    '{{128{1'b1}}, 5'd9, 1'b0, 128'h0, 1'b0},
    '{{128{1'b1}}, 5'd15, 1'b0, 128'h0, 1'b0},
    '{{128{1'b1}}, 5'd0, 1'b1, 128'h0, 1'b1},
    '{{128{1'b1}}, 5'd17, 1'b0, 128'h0, 1'b0},
    '{{128{1'b1}}, 5'd31, 1'b0, 128'h0, 1'b0},
    '{128'haaaa5555aaaa5555aaaa5555aaaa5555, 5'd16, 1'b1, 128'h0, 1'b0},
    '{128'h5555aaaa5555aaaa5555aaaa5555aaaa, 5'd16, 1'b0, 128'h0, 1'b0},
    '{128'h0f0f0f0f0f0f0f0f0f0f0f0f0f0f0f0f, 5'd16, 1'b0, 128'h0, 1'b0}
  };

  initial begin
    int phase, n_items;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct_in = 0; idle_pct_out = 0; hold_off_req = 1'b0;
    n_errors = 0;
    ctr_q = '0;
    for (int i = 0; i < 4; i++) cfg_regs[i] = '0;
    for (int i = 0; i < 44; i++) sched_words[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the FIPS key and then an IV that rolls over.
    load_key_iv(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h0011223344556677, 64'h8899aabbccddeeff);
    foreach (dir_rows[i]) begin
      send_block(dir_rows[i].blk, dir_rows[i].nb, dir_rows[i].first,
                 dir_rows[i].exp_blk, dir_rows[i].exp_given);
      if (i == 8) begin
        drain();
        load_key_iv({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 64'hffff_ffff_ffff_fffe);
      end
    end
    drain();
    load_key_iv(64'h0, 64'h0, 64'h0, 64'h0);
    for (int i = 0; i < 3; i++) send_block(rand128(), 5'd16, i == 0, '0, 1'b0);
    drain();

    // Random part: messages of random length under fresh keys, four idling
    // phases, with a long receiver hold-off in the first one.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  hold_off_req = 1'b1; end
        1: begin idle_pct_in = 48; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 48; end
        default: begin idle_pct_in = 13; idle_pct_out = 13; end
      endcase
      load_key_iv({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, ($urandom_range(3) == 0) ?
                  64'hffff_ffff_ffff_fff0 | 64'($urandom_range(15)) :
                  {$urandom, $urandom});
      n_items = 0;
      while (n_items < 160) begin
        int msg_len;
        msg_len = $urandom_range(12, 1);
        for (int b = 0; b < msg_len; b++) begin
          logic [4:0] nb;
          nb = 5'd16;
          if (b == msg_len - 1)
            nb = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                 5'($urandom_range(16, 1));
          send_block(rand128(), nb, b == 0, '0, 1'b0);
          n_items++;
        end
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aesc_pkg.sv
rtl/aesc_round.sv
rtl/aes128_ctr_cipher.sv
dv/aes128_ctr_cipher_tb.sv
